[hw/rtl/ctw_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, operation codes and queue entry type of the text console cell writer.
package ctw_pkg;

    // Screen geometry
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_CELLS    = 4;
    localparam int VT_ROWS      = 4;
    localparam int SCREEN_CELLS = COLUMNS * ROWS;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 2 * CHAR_W;

    // Internal widths
    localparam int ADDR_W = $clog2(SCREEN_CELLS);
    localparam int CUR_W  = $clog2(SCREEN_CELLS + 1);

    // Control bytes
    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'd11;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // Operation decoded by the front end
    typedef enum logic [2:0] {
        OP_NOP,
        OP_READ,
        OP_PRINT,
        OP_TAB,
        OP_VT,
        OP_CR,
        OP_NL
    } op_code_t;

    typedef struct packed {
        op_code_t            code;
        logic [CHAR_W-1:0]   char_code;
        logic [IDX_W-1:0]    cell_index;
    } op_t;

endpackage

[hw/rtl/ctw_channels.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the text console cell writer.
interface ctw_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [ctw_pkg::CHAR_W-1:0]   char_code;
    logic [ctw_pkg::IDX_W-1:0]    cell_index;

    modport source (output valid, output func, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input func, input char_code, input cell_index,
                    output ready);
endinterface

interface ctw_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ctw_pkg::CHAR_W-1:0]   read_char;
    logic [ctw_pkg::CHAR_W-1:0]   read_color;
    logic [ctw_pkg::IDX_W-1:0]    cursor_cell;
    logic                         scrolled;

    modport source (output valid, output read_char, output read_color,
                    output cursor_cell, output scrolled, input ready);
    modport sink   (input valid, input read_char, input read_color,
                    input cursor_cell, input scrolled, output ready);
endinterface

[hw/rtl/text_console_cell_writer_top.sv]
`timescale 1ns / 1ps
// Top level of the text console cell writer.
//
// Usage: each request transfer on req carries one byte to put (func 0) or a
// pure read (func 1) plus a cell index; every request gives exactly one
// response transfer on rsp with the addressed cell (character, color), the
// cursor after the step and a scroll flag. cfg_wr_en/cfg_wr_data set the
// color byte written with each printed character; write it only when idle.
// A request passes the queue, the back end idle state and the response state
// before it reaches the response register; tab and carriage return pass an
// extra move state for the cursor divide. The back end sequencer pops one
// item from the queue and loads the response register before it pops the
// next. A print at the end of the screen scrolls through the screen memory
// (one write and one read port): a read and a write state per moved cell
// and a clear state per cleared cell. After reset a clearing pass writes every
// cell to zero, one per cycle, and req.ready stays low meanwhile.
// A two-entry queue parts front and back end; a stalled rsp holds the
// response register, the back end waits and req fills the queue, then stalls.
module text_console_cell_writer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ctw_pkg::CHAR_W-1:0]  cfg_wr_data,
    ctw_req_if.sink                     req,
    ctw_rsp_if.source                   rsp
);
    import ctw_pkg::*;

    logic q_push, q_full, q_pop, q_empty, init_busy;
    op_t  q_data, q_head;

    ctw_front u_front (
        .req       (req),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    ctw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    ctw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .init_busy   (init_busy),
        .rsp         (rsp)
    );

endmodule

[hw/rtl/ctw_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue of decoded operations between front end and back end.
module ctw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ctw_pkg::op_t  push_data,
    output logic          full,
    input  logic          pop,
    output ctw_pkg::op_t  head,
    output logic          empty
);
    import ctw_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/ctw_front.sv]
`timescale 1ns / 1ps
// Front end: takes request transfers and decodes each byte into an operation.
module ctw_front (
    ctw_req_if.sink       req,
    input  logic          q_full,
    input  logic          init_busy,
    output logic          q_push,
    output ctw_pkg::op_t  q_data
);
    import ctw_pkg::*;

    // Hold off while the queue is full or the screen is still being cleared
    assign req.ready = !q_full && !init_busy;
    assign q_push    = req.valid && req.ready;

    // Byte classification
    always_comb
    begin
        q_data.char_code  = req.char_code;
        q_data.cell_index = req.cell_index;
        if (req.func)
        begin
            q_data.code = OP_READ;
        end
        else
        begin
            unique case (req.char_code)
                CH_TAB:        q_data.code = OP_TAB;
                CH_VT:         q_data.code = OP_VT;
                CH_CR:         q_data.code = OP_CR;
                CH_NL:         q_data.code = OP_NL;
                CH_NUL, CH_BS: q_data.code = OP_NOP;
                default:       q_data.code = OP_PRINT;
            endcase
        end
    end

endmodule

[hw/rtl/ctw_back.sv]
`timescale 1ns / 1ps
// Back end: cursor logic, screen memory with scroll and clear sweeps, response register.
module ctw_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ctw_pkg::CHAR_W-1:0]  cfg_wr_data,
    input  logic                        q_empty,
    input  ctw_pkg::op_t                q_head,
    output logic                        q_pop,
    output logic                        init_busy,
    ctw_rsp_if.source                   rsp
);
    import ctw_pkg::*;

    // Reciprocal constants for cursor / COLUMNS and cursor / TAB_CELLS
    localparam int DIV_SH    = CUR_W + 9;
    localparam int RECIP_W   = DIV_SH + 1;
    localparam int PROD_W    = CUR_W + RECIP_W;
    localparam int COL_RECIP = (1 << DIV_SH) / COLUMNS + 1;
    localparam int TAB_RECIP = (1 << DIV_SH) / TAB_CELLS + 1;
    localparam int STEP_W    = CUR_W + 2;

    localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'(SCREEN_CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(SCREEN_CELLS - 1);
    localparam logic [CUR_W-1:0]  END_CUR   = CUR_W'(SCREEN_CELLS);
    localparam logic [CUR_W-1:0]  LAST_ROW  = CUR_W'(SCREEN_CELLS - COLUMNS);
    localparam logic [IDX_W:0]    IDX_LIMIT = (IDX_W + 1)'(SCREEN_CELLS);

    typedef enum logic [7:0] {
        ST_INIT    = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_MOVE    = 8'b0000_0100,
        ST_SCR_RD  = 8'b0000_1000,
        ST_SCR_WR  = 8'b0001_0000,
        ST_SCR_CLR = 8'b0010_0000,
        ST_PUT     = 8'b0100_0000,
        ST_RESP    = 8'b1000_0000
    } state_t;

    function automatic logic [CUR_W-1:0] step_clamp(input logic [CUR_W-1:0]  cur,
                                                    input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] sum;
        sum = STEP_W'(cur) + step;
        if (sum > STEP_W'(SCREEN_CELLS))
        begin
            return END_CUR;
        end
        return CUR_W'(sum);
    endfunction

    state_t              state_reg, state_next;
    logic [CUR_W-1:0]    cursor_reg, cursor_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic                scrolled_reg, scrolled_next;
    op_t                 op_reg, op_next;
    logic [CHAR_W-1:0]   color_reg;
    logic [CUR_W-1:0]    q_col_reg, q_tab_reg;

    logic [PROD_W-1:0]   prod_col, prod_tab;
    logic [CUR_W-1:0]    row_base, tab_base;

    logic [CELL_W-1:0]   mem [SCREEN_CELLS];
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [CELL_W-1:0]   mem_wdata, mem_rdata_reg;
    logic                fwd_reg, in_range_reg;
    logic [CELL_W-1:0]   fwd_data_reg, read_cell;
    op_t                 rd_op;
    logic                rd_in_range;

    logic                rsp_valid_reg, rsp_load;
    logic [CHAR_W-1:0]   rsp_char_reg, rsp_color_reg;
    logic [IDX_W-1:0]    rsp_cursor_reg;
    logic                rsp_scrolled_reg;

    assign init_busy = (state_reg == ST_INIT);

    // Quotient estimates, registered before the constant multiply back
    assign prod_col = PROD_W'(cursor_reg) * PROD_W'(COL_RECIP);
    assign prod_tab = PROD_W'(cursor_reg) * PROD_W'(TAB_RECIP);
    assign row_base = CUR_W'(q_col_reg * CUR_W'(COLUMNS));
    assign tab_base = CUR_W'(q_tab_reg * CUR_W'(TAB_CELLS));

    // Step read targets the popped op in idle, the held op elsewhere
    assign rd_op       = (state_reg == ST_IDLE) ? q_head : op_reg;
    assign rd_in_range = ({1'b0, rd_op.cell_index} < IDX_LIMIT);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        ptr_next      = ptr_reg;
        scrolled_next = scrolled_reg;
        op_next       = op_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = ADDR_W'(cursor_reg);
        mem_wdata     = {color_reg, rd_op.char_code};
        mem_re        = 1'b0;
        mem_raddr     = ADDR_W'(rd_op.cell_index);
        rsp_load      = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = '0;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    op_next       = q_head;
                    scrolled_next = 1'b0;
                    state_next    = ST_RESP;
                    unique case (q_head.code)
                        OP_TAB, OP_CR:
                        begin
                            state_next = ST_MOVE;
                        end
                        OP_VT:
                        begin
                            cursor_next = step_clamp(cursor_reg, STEP_W'(VT_ROWS * COLUMNS));
                            mem_re      = 1'b1;
                        end
                        OP_NL:
                        begin
                            cursor_next = step_clamp(cursor_reg, STEP_W'(COLUMNS));
                            mem_re      = 1'b1;
                        end
                        OP_PRINT:
                        begin
                            if (cursor_reg >= END_CUR)
                            begin
                                scrolled_next = 1'b1;
                                ptr_next      = '0;
                                state_next    = ST_SCR_RD;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                cursor_next = step_clamp(cursor_reg, STEP_W'(1));
                                mem_re      = 1'b1;
                            end
                        end
                        default:
                        begin
                            mem_re = 1'b1;
                        end
                    endcase
                end
            end
            ST_MOVE:
            begin
                if (op_reg.code == OP_CR)
                begin
                    cursor_next = row_base;
                end
                else
                begin
                    cursor_next = step_clamp(tab_base, STEP_W'(TAB_CELLS));
                end
                mem_re     = 1'b1;
                state_next = ST_RESP;
            end
            ST_SCR_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_reg + ADDR_W'(COLUMNS);
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = mem_rdata_reg;
                ptr_next   = ptr_reg + 1'b1;
                state_next = (ptr_reg == LAST_MOVE) ? ST_SCR_CLR : ST_SCR_RD;
            end
            ST_SCR_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = '0;
                ptr_next  = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next    = '0;
                    cursor_next = LAST_ROW;
                    state_next  = ST_PUT;
                end
            end
            ST_PUT:
            begin
                mem_we      = 1'b1;
                cursor_next = step_clamp(cursor_reg, STEP_W'(1));
                mem_re      = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cursor_reg    <= '0;
            ptr_reg       <= '0;
            scrolled_reg  <= 1'b0;
            color_reg     <= 8'd7;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            ptr_reg      <= ptr_next;
            scrolled_reg <= scrolled_next;
            if (cfg_wr_en)
            begin
                color_reg <= cfg_wr_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Held operation and quotients
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        if (state_reg == ST_IDLE)
        begin
            q_col_reg <= prod_col[DIV_SH +: CUR_W];
            q_tab_reg <= prod_tab[DIV_SH +: CUR_W];
        end
    end

    // Screen memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Forward a cell written in the same cycle as the step read
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            fwd_reg      <= mem_we && (mem_waddr == mem_raddr);
            fwd_data_reg <= mem_wdata;
            in_range_reg <= rd_in_range;
        end
    end

    assign read_cell = !in_range_reg ? '0 : (fwd_reg ? fwd_data_reg : mem_rdata_reg);

    // Response register
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_char_reg     <= read_cell[CHAR_W-1:0];
            rsp_color_reg    <= read_cell[CELL_W-1:CHAR_W];
            rsp_cursor_reg   <= IDX_W'(cursor_reg);
            rsp_scrolled_reg <= scrolled_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_char   = rsp_char_reg;
    assign rsp.read_color  = rsp_color_reg;
    assign rsp.cursor_cell = rsp_cursor_reg;
    assign rsp.scrolled    = rsp_scrolled_reg;

endmodule

[dv/tb_text_console_cell_writer_top.sv]
`timescale 1ns / 1ps
// Testbench for the text console cell writer: directed and random byte streams checked against a screen model.

import ctw_pkg::*;

// One response transfer as seen on the rsp channel
typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_color;
    logic [IDX_W-1:0]  cursor_cell;
    logic              scrolled;
} cell_rsp_t;

// Screen model plus the queue of responses still owed by the block
class console_scoreboard;
    bit [CELL_W-1:0] screen [SCREEN_CELLS];
    int unsigned     cursor;
    bit [CHAR_W-1:0] color;
    cell_rsp_t       owed_rsp [$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     scrolls;
    int unsigned     reads;

    function new();
        foreach (screen[i])
            screen[i] = '0;
        cursor     = 0;
        color      = 8'd7;
        mismatches = 0;
        checked    = 0;
        scrolls    = 0;
        reads      = 0;
    endfunction

    function int unsigned clamp_cursor(int unsigned v);
        return (v > SCREEN_CELLS) ? SCREEN_CELLS : v;
    endfunction

    // Apply one accepted request to the screen and queue the response it owes
    function void note_request(bit func, bit [CHAR_W-1:0] ch, bit [IDX_W-1:0] idx);
        cell_rsp_t       rsp;
        bit [CELL_W-1:0] cell_word;
        rsp = '0;
        if (func)
        begin
            reads++;
        end
        else
        begin
            unique case (ch)
                CH_TAB: cursor = clamp_cursor(cursor + TAB_CELLS - cursor % TAB_CELLS);
                CH_VT:  cursor = clamp_cursor(cursor + VT_ROWS * COLUMNS);
                CH_CR:  cursor = cursor - cursor % COLUMNS;
                CH_NL:  cursor = clamp_cursor(cursor + COLUMNS);
                CH_NUL, CH_BS: ;
                default:
                begin
                    // printing past the end rolls the screen up one row first
                    if (cursor >= SCREEN_CELLS)
                    begin
                        for (int i = 0; i < SCREEN_CELLS - COLUMNS; i++)
                            screen[i] = screen[i + COLUMNS];
                        for (int i = SCREEN_CELLS - COLUMNS; i < SCREEN_CELLS; i++)
                            screen[i] = '0;
                        cursor       = SCREEN_CELLS - COLUMNS;
                        rsp.scrolled = 1'b1;
                        scrolls++;
                    end
                    screen[cursor] = {color, ch};
                    cursor = clamp_cursor(cursor + 1);
                end
            endcase
        end
        cell_word       = (idx < SCREEN_CELLS) ? screen[idx] : '0;
        rsp.read_char   = cell_word[CHAR_W-1:0];
        rsp.read_color  = cell_word[CELL_W-1:CHAR_W];
        rsp.cursor_cell = IDX_W'(cursor);
        owed_rsp.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
        if (got !== want)
        begin
            if (mismatches < 40)
                $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare one response transfer with the oldest owed response
    function void check_response(cell_rsp_t got);
        cell_rsp_t want;
        if (owed_rsp.size() == 0)
        begin
            $display("%0t ns: unexpected response, expected none actual char %0d color %0d",
                     $time, got.read_char, got.read_color);
            $display("%0t ns:   cursor %0d scrolled %0d", $time, got.cursor_cell, got.scrolled);
            mismatches++;
            return;
        end
        want = owed_rsp.pop_front();
        checked++;
        compare_field("read_char", want.read_char, got.read_char);
        compare_field("read_color", want.read_color, got.read_color);
        compare_field("cursor_cell", want.cursor_cell, got.cursor_cell);
        compare_field("scrolled", want.scrolled, got.scrolled);
    endfunction
endclass

module tb_text_console_cell_writer_top;
    import ctw_pkg::*;

    localparam int unsigned RUN_LIMIT   = 4_000_000;
    localparam int          LONG_HOLD   = 400;
    localparam int          PHASE_ITEMS = 315;
    localparam int          N_PHASES    = 6;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CHAR_W-1:0] cfg_wr_data;

    ctw_req_if req_if ();
    ctw_rsp_if rsp_if ();

    console_scoreboard sb = new();

    bit          idle_on;
    bit          hold_request;
    int unsigned cycle_count = 0;
    int unsigned transfers_in = 0;

    text_console_cell_writer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if),
        .rsp         (rsp_if)
    );

    // Clock, 20 ns period
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still owed",
                     cycle_count, sb.owed_rsp.size());
            $display("tb_text_console_cell_writer_top: FAIL");
            $finish;
        end
    end

    // Offer one request and wait for its transfer; valid stays high afterwards
    task automatic send_item(bit func, bit [CHAR_W-1:0] ch, bit [IDX_W-1:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= func;
        req_if.char_code  <= ch;
        req_if.cell_index <= idx;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(func, ch, idx);
        transfers_in++;
    endtask

    // Stop offering and wait until every owed response has come back
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.owed_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_color(bit [CHAR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.color = value;
    endtask

    // Printable byte: mostly ASCII text, sometimes any non-control byte
    function automatic bit [CHAR_W-1:0] pick_glyph();
        bit [CHAR_W-1:0] g;
        if ($urandom_range(0, 3) != 0)
            return CHAR_W'($urandom_range(32, 126));
        do
            g = CHAR_W'($urandom_range(1, 255));
        while (g inside {CH_BS, CH_TAB, CH_NL, CH_VT, CH_CR});
        return g;
    endfunction

    // Cell to report: anywhere incl. off screen, bottom rows, or top row
    function automatic bit [IDX_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return IDX_W'($urandom_range(0, 2047));
        else if (r < 8)
            return IDX_W'($urandom_range(SCREEN_CELLS - 2 * COLUMNS, SCREEN_CELLS - 1));
        return IDX_W'($urandom_range(0, COLUMNS - 1));
    endfunction

    // One line of text with tabs and reads mixed in, then a line ending
    task automatic send_line();
        int len;
        int roll;
        len = $urandom_range(0, 30);
        for (int k = 0; k < len; k++)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                send_item(1'b0, CH_TAB, pick_index());
            else if (roll == 1)
                send_item(1'b1, pick_glyph(), pick_index());
            else
                send_item(1'b0, pick_glyph(), pick_index());
        end
        roll = $urandom_range(0, 9);
        if (roll < 6)
        begin
            send_item(1'b0, CH_CR, pick_index());
            send_item(1'b0, CH_NL, pick_index());
        end
        else if (roll < 8)
        begin
            send_item(1'b0, CH_NL, pick_index());
        end
        else if (roll == 8)
        begin
            send_item(1'b0, CH_NL, pick_index());
            send_item(1'b0, CH_CR, pick_index());
        end
        else
        begin
            send_item(1'b0, CH_VT, pick_index());
        end
    endtask

    // Response side: random stalls, one long hold-off on request
    initial
    begin : rsp_drain
        cell_rsp_t got;
        int        stall;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            else
            begin
                stall = idle_on ? $urandom_range(0, 12) : 0;
            end
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            got.read_char   = rsp_if.read_char;
            got.read_color  = rsp_if.read_color;
            got.cursor_cell = rsp_if.cursor_cell;
            got.scrolled    = rsp_if.scrolled;
            sb.check_response(got);
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned phase_start;
        int          pick;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        req_if.valid      = 1'b0;
        req_if.func       = 1'b0;
        req_if.char_code  = '0;
        req_if.cell_index = '0;
        idle_on           = 1'b1;
        hold_request      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored bytes, field extremes, every control, end of screen
        send_item(1'b0, CH_NUL, 11'd0);
        send_item(1'b0, CH_BS, 11'd2047);
        send_item(1'b0, 8'd65, 11'd0);
        send_item(1'b0, 8'd255, 11'd1);
        send_item(1'b0, CH_TAB, 11'd1);
        send_item(1'b0, CH_TAB, 11'd0);     // on a tab stop, still moves
        send_item(1'b0, 8'd1, 11'd8);
        send_item(1'b0, CH_CR, 11'd8);
        send_item(1'b0, CH_NL, 11'd0);
        send_item(1'b0, CH_VT, 11'd0);
        send_item(1'b1, 8'd0, 11'd1999);
        send_item(1'b1, 8'd0, 11'd2000);    // off screen reads zero
        send_item(1'b1, 8'd255, 11'd2047);
        repeat (5) send_item(1'b0, CH_VT, 11'd1);   // saturates at end of screen
        send_item(1'b0, CH_NL, 11'd0);
        send_item(1'b0, CH_CR, 11'd0);
        send_item(1'b0, CH_TAB, 11'd0);
        send_item(1'b0, 8'd90, 11'd1920);   // print at end: scroll
        send_item(1'b1, CH_TAB, 11'd1840);
        send_item(1'b1, CH_NL, 11'd1920);

        // Random phases, each with its own color and idling pattern
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            if (ph == 0)
                write_color(8'h00);
            else if (ph == 1)
                write_color(8'hFF);
            else
                write_color(CHAR_W'($urandom_range(0, 255)));
            idle_on = (ph != 2);
            if (ph == 2 || ph == 4)
                hold_request = 1'b1;
            phase_start = transfers_in;
            while (transfers_in - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_line();
                else if (pick < 85)
                    repeat ($urandom_range(1, 4))
                        send_item(1'b1, CHAR_W'($urandom_range(0, 255)), pick_index());
                else
                    send_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 2047)));
            end
        end
        settle();

        $display("run: %0d request transfers, %0d responses checked, %0d reads, %0d scrolls",
                 transfers_in, sb.checked, sb.reads, sb.scrolls);
        $display("run: reset color, 0x00, 0xff and random colors; gap-free phase and long hold-offs");
        if (sb.mismatches == 0 && sb.owed_rsp.size() == 0)
            $display("tb_text_console_cell_writer_top: PASS");
        else
            $display("tb_text_console_cell_writer_top: FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/ctw_pkg.sv
hw/rtl/ctw_channels.sv
hw/rtl/ctw_queue.sv
hw/rtl/ctw_front.sv
hw/rtl/ctw_back.sv
hw/rtl/text_console_cell_writer_top.sv
dv/tb_text_console_cell_writer_top.sv
